[hdl/qau_pkg.sv]
// Shared types, constants and clip helper for the quaternion arithmetic unit.
package qau_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int PROD_W            = 2 * DATA_WIDTH;
   localparam int UPROD_W           = 2 * DATA_WIDTH + 1;
   localparam int SUM_W             = 2 * DATA_WIDTH + 3;
   localparam int MID_W             = DATA_WIDTH + 1;

   localparam logic [1:0] FUNC_MUL  = 2'd0;
   localparam logic [1:0] FUNC_ROT  = 2'd1;
   localparam logic [1:0] FUNC_CONJ = 2'd2;

   localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] MID_MAX = (SUM_W'(1) <<< DATA_WIDTH) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] MID_MIN = -MID_MAX;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [DATA_WIDTH-1:0] a_w;
      logic signed [DATA_WIDTH-1:0] a_x;
      logic signed [DATA_WIDTH-1:0] a_y;
      logic signed [DATA_WIDTH-1:0] a_z;
      logic signed [DATA_WIDTH-1:0] b_w;
      logic signed [DATA_WIDTH-1:0] b_x;
      logic signed [DATA_WIDTH-1:0] b_y;
      logic signed [DATA_WIDTH-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r_w;
      logic signed [DATA_WIDTH-1:0] r_x;
      logic signed [DATA_WIDTH-1:0] r_y;
      logic signed [DATA_WIDTH-1:0] r_z;
      logic                         saturated;
   } rsp_type;

   // front half to back half: final parts, or t for rotate
   typedef struct packed {
      logic [1:0]                   func;
      logic signed [MID_W-1:0]      q_w;
      logic signed [MID_W-1:0]      q_x;
      logic signed [MID_W-1:0]      q_y;
      logic signed [MID_W-1:0]      q_z;
      logic signed [DATA_WIDTH-1:0] a_x;
      logic signed [DATA_WIDTH-1:0] a_y;
      logic signed [DATA_WIDTH-1:0] a_z;
      logic signed [DATA_WIDTH-1:0] v_x;
      logic signed [DATA_WIDTH-1:0] v_y;
      logic signed [DATA_WIDTH-1:0] v_z;
      logic                         sat;
   } mid_type;

   typedef struct packed {
      logic                    hit;
      logic signed [MID_W-1:0] val;
   } clip_type;

   function automatic clip_type clip_range(input logic signed [SUM_W-1:0] v,
                                           input logic signed [SUM_W-1:0] lo,
                                           input logic signed [SUM_W-1:0] hi);
      clip_type c;
      c.hit = 1'b1;
      if (v < lo) begin
         c.val = lo[MID_W-1:0];
      end else if (v > hi) begin
         c.val = hi[MID_W-1:0];
      end else begin
         c.hit = 1'b0;
         c.val = v[MID_W-1:0];
      end
      return c;
   endfunction

endpackage

[hdl/qau_back.sv]
// Back half of the pipeline: second cross product, final combine, output register.
module qau_back import qau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  mid_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic signed [SUM_W-1:0] ROUND_K = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic ready4, ready5, ready6;

   logic                      s4_valid_ff;
   mid_type                   s4_mid_ff;
   logic signed [UPROD_W-1:0] s4_up_ff [6];
   logic signed [UPROD_W-1:0] s4_up_in [6];

   logic                    s5_valid_ff;
   mid_type                 s5_mid_ff;
   logic signed [SUM_W-1:0] s5_u_ff [3];
   logic signed [SUM_W-1:0] s5_u_in [3];

   logic       rsp_valid_ff;
   logic [1:0] s6_func_ff;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;

   assign ready6   = !rsp_valid_ff || !rsp_stall;
   assign ready5   = !s5_valid_ff || ready6;
   assign ready4   = !s4_valid_ff || ready5;
   assign in_ready = ready4;

   // u = aq x t
   always_comb begin
      s4_up_in[0] = in_data.a_y * in_data.q_z;
      s4_up_in[1] = in_data.a_z * in_data.q_y;
      s4_up_in[2] = in_data.a_z * in_data.q_x;
      s4_up_in[3] = in_data.a_x * in_data.q_z;
      s4_up_in[4] = in_data.a_x * in_data.q_y;
      s4_up_in[5] = in_data.a_y * in_data.q_x;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s5_u_in[k] = (SUM_W'(s4_up_ff[2*k]) - SUM_W'(s4_up_ff[2*k+1]) + ROUND_K)
                      >>> FRAC_BITS;
      end
   end

   always_comb begin
      logic signed [DATA_WIDTH-1:0] v_arr [3];
      logic signed [DATA_WIDTH-1:0] r_arr [3];
      logic signed [SUM_W-1:0]      tot;
      clip_type                     cu;
      clip_type                     co;
      logic                         hit;
      v_arr[0]    = s5_mid_ff.v_x;
      v_arr[1]    = s5_mid_ff.v_y;
      v_arr[2]    = s5_mid_ff.v_z;
      hit         = 1'b0;
      rsp_data_in = '0;
      for (int k = 0; k < 3; k++) begin
         cu       = clip_range(s5_u_ff[k], MID_MIN, MID_MAX);
         tot      = (SUM_W'(cu.val) <<< 1) + SUM_W'(v_arr[k]);
         co       = clip_range(tot, OUT_MIN, OUT_MAX);
         r_arr[k] = co.val[DATA_WIDTH-1:0];
         hit      = hit | cu.hit | co.hit;
      end
      case (s5_mid_ff.func)
         FUNC_ROT: begin
            rsp_data_in.r_x       = r_arr[0];
            rsp_data_in.r_y       = r_arr[1];
            rsp_data_in.r_z       = r_arr[2];
            rsp_data_in.saturated = s5_mid_ff.sat | hit;
         end
         FUNC_MUL, FUNC_CONJ: begin
            rsp_data_in.r_w       = s5_mid_ff.q_w[DATA_WIDTH-1:0];
            rsp_data_in.r_x       = s5_mid_ff.q_x[DATA_WIDTH-1:0];
            rsp_data_in.r_y       = s5_mid_ff.q_y[DATA_WIDTH-1:0];
            rsp_data_in.r_z       = s5_mid_ff.q_z[DATA_WIDTH-1:0];
            rsp_data_in.saturated = s5_mid_ff.sat;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready4) s4_valid_ff <= in_valid;
         if (ready5) s5_valid_ff <= s4_valid_ff;
         if (ready6) rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         s4_mid_ff <= in_data;
         s4_up_ff  <= s4_up_in;
      end
      if (ready5) begin
         s5_mid_ff <= s4_mid_ff;
         s5_u_ff   <= s5_u_in;
      end
      if (ready6) begin
         s6_func_ff  <= s5_mid_ff.func;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_unused_func_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && s6_func_ff != FUNC_MUL && s6_func_ff != FUNC_ROT &&
       s6_func_ff != FUNC_CONJ) |-> (rsp_data_ff == '0))
      else $error("unused opcode gave a nonzero result");

   a_rot_scalar_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && s6_func_ff == FUNC_ROT) |-> (rsp_data_ff.r_w == '0))
      else $error("rotate result has nonzero scalar");

   a_s5_hold: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && !ready6) |=> (s5_valid_ff && $stable(s5_mid_ff)))
      else $error("stage 5 transaction changed while held");

endmodule

[hdl/quaternion_arith_unit_top.sv]
// Top level of the quaternion arithmetic unit: front pipeline stages and back half.
//
// Usage:
//   req channel carries one transaction per operation: func plus quaternions a and b.
//   func 0: Hamilton product a*b. func 1: rotate vector (b_x, b_y, b_z) by a.
//   func 2: conjugate of a. Any other code returns all zeros.
//   rsp channel returns one transaction per request, in order, with r_w..r_z and
//   the saturated flag. Parts are Q2.14 at the default FRAC_BITS.
//   Throughput is one transaction per cycle while rsp_stall is low; the six
//   register stages are products, sums and rounding, clipping, second cross
//   products, rounding, and final combine with the output register.
//   Reset clears all stage valid bits; the pipe is empty and ready right after.
//   When the receiver asserts rsp_stall the result holds; earlier stages keep
//   advancing into empty slots, so req_stall rises only when every stage ahead
//   of the input is full.
module quaternion_arith_unit_top import qau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic signed [SUM_W-1:0] ROUND_K = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic ready1, ready2, ready3, back_ready;

   logic signed [DATA_WIDTH-1:0] a_vec [4];
   logic signed [DATA_WIDTH-1:0] b_vec [4];

   logic                         s1_valid_ff;
   logic [1:0]                   s1_func_ff;
   logic signed [PROD_W-1:0]     s1_prod_ff [4][4];
   logic signed [PROD_W-1:0]     s1_prod_in [4][4];
   logic signed [DATA_WIDTH-1:0] s1_a_ff [4];
   logic signed [DATA_WIDTH-1:0] s1_v_ff [3];

   logic                         s2_valid_ff;
   logic [1:0]                   s2_func_ff;
   logic signed [SUM_W-1:0]      s2_sum_ff [4];
   logic signed [SUM_W-1:0]      s2_sum_in [4];
   logic signed [DATA_WIDTH-1:0] s2_a_ff [4];
   logic signed [DATA_WIDTH-1:0] s2_v_ff [3];

   logic    s3_valid_ff;
   mid_type s3_ff;
   mid_type s3_in;

   assign ready3    = !s3_valid_ff || back_ready;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   // all sixteen a_i * b_j products; index 0 is w, then x, y, z
   always_comb begin
      a_vec[0] = req_data.a_w;
      a_vec[1] = req_data.a_x;
      a_vec[2] = req_data.a_y;
      a_vec[3] = req_data.a_z;
      b_vec[0] = req_data.b_w;
      b_vec[1] = req_data.b_x;
      b_vec[2] = req_data.b_y;
      b_vec[3] = req_data.b_z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_prod_in[i][j] = a_vec[i] * b_vec[j];
         end
      end
   end

   // product vector parts equal t plus the b_w terms
   always_comb begin
      logic                    mul_op;
      logic signed [SUM_W-1:0] raw [4];
      mul_op = (s1_func_ff == FUNC_MUL);
      raw[0] = SUM_W'(s1_prod_ff[0][0]) - SUM_W'(s1_prod_ff[1][1])
             - SUM_W'(s1_prod_ff[2][2]) - SUM_W'(s1_prod_ff[3][3]);
      raw[1] = SUM_W'(s1_prod_ff[0][1]) + SUM_W'(s1_prod_ff[2][3])
             - SUM_W'(s1_prod_ff[3][2])
             + (mul_op ? SUM_W'(s1_prod_ff[1][0]) : SUM_W'(0));
      raw[2] = SUM_W'(s1_prod_ff[0][2]) + SUM_W'(s1_prod_ff[3][1])
             - SUM_W'(s1_prod_ff[1][3])
             + (mul_op ? SUM_W'(s1_prod_ff[2][0]) : SUM_W'(0));
      raw[3] = SUM_W'(s1_prod_ff[0][3]) + SUM_W'(s1_prod_ff[1][2])
             - SUM_W'(s1_prod_ff[2][1])
             + (mul_op ? SUM_W'(s1_prod_ff[3][0]) : SUM_W'(0));
      for (int k = 0; k < 4; k++) begin
         s2_sum_in[k] = (raw[k] + ROUND_K) >>> FRAC_BITS;
      end
   end

   always_comb begin
      logic signed [MID_W-1:0] q [4];
      clip_type                c;
      logic                    hit;
      hit = 1'b0;
      c   = '0;
      for (int k = 0; k < 4; k++) begin
         q[k] = '0;
      end
      case (s2_func_ff)
         FUNC_MUL: begin
            for (int k = 0; k < 4; k++) begin
               c    = clip_range(s2_sum_ff[k], OUT_MIN, OUT_MAX);
               q[k] = c.val;
               hit  = hit | c.hit;
            end
         end
         FUNC_ROT: begin
            for (int k = 1; k < 4; k++) begin
               c    = clip_range(s2_sum_ff[k], MID_MIN, MID_MAX);
               q[k] = c.val;
               hit  = hit | c.hit;
            end
         end
         FUNC_CONJ: begin
            q[0] = MID_W'(s2_a_ff[0]);
            for (int k = 1; k < 4; k++) begin
               c    = clip_range(-SUM_W'(s2_a_ff[k]), OUT_MIN, OUT_MAX);
               q[k] = c.val;
               hit  = hit | c.hit;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      s3_in.func = s2_func_ff;
      s3_in.q_w  = q[0];
      s3_in.q_x  = q[1];
      s3_in.q_y  = q[2];
      s3_in.q_z  = q[3];
      s3_in.a_x  = s2_a_ff[1];
      s3_in.a_y  = s2_a_ff[2];
      s3_in.a_z  = s2_a_ff[3];
      s3_in.v_x  = s2_v_ff[0];
      s3_in.v_y  = s2_v_ff[1];
      s3_in.v_z  = s2_v_ff[2];
      s3_in.sat  = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ready1) s1_valid_ff <= req_valid;
         if (ready2) s2_valid_ff <= s1_valid_ff;
         if (ready3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_func_ff <= req_data.func;
         s1_prod_ff <= s1_prod_in;
         s1_a_ff    <= a_vec;
         s1_v_ff[0] <= req_data.b_x;
         s1_v_ff[1] <= req_data.b_y;
         s1_v_ff[2] <= req_data.b_z;
      end
      if (ready2) begin
         s2_func_ff <= s1_func_ff;
         s2_sum_ff  <= s2_sum_in;
         s2_a_ff    <= s1_a_ff;
         s2_v_ff    <= s1_v_ff;
      end
      if (ready3) begin
         s3_ff <= s3_in;
      end
   end

   qau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (back_ready),
      .in_data   (s3_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !back_ready) |=> (s3_valid_ff && $stable(s3_ff)))
      else $error("stage 3 transaction changed while held");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (!back_ready && s1_valid_ff && s2_valid_ff && s3_valid_ff) |-> req_stall)
      else $error("request taken with the pipe full");

   a_mid_fits: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.func != FUNC_ROT) |->
      (s3_ff.q_w[MID_W-1] == s3_ff.q_w[MID_W-2] &&
       s3_ff.q_x[MID_W-1] == s3_ff.q_x[MID_W-2] &&
       s3_ff.q_y[MID_W-1] == s3_ff.q_y[MID_W-2] &&
       s3_ff.q_z[MID_W-1] == s3_ff.q_z[MID_W-2]))
      else $error("final part out of output range");

endmodule
